>>> hw/rtl/fixed_slot_free_list_allocator_macros.svh
// Assertion macros shared by the free-list allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FSFL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FSFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/fsfl_pkg.sv
// Shared types and constants of the fixed-slot free-list allocator.
// No dependencies; imported by every module of the block except fsfl_ram.
package fsfl_pkg;

   // Field widths.
   localparam int BYTES_W     = 13;
   localparam int COUNT_W     = 11;
   localparam int REQ_BYTES_W = 16;
   localparam int ALIGN_W     = 13;
   localparam int OFFSET_W    = 22;
   localparam int STATUS_W    = 3;

   // Divider geometry: the dividend is a byte offset or a slot size, the divisor a slot size or an alignment.
   localparam int DIV_W      = OFFSET_W;
   localparam int DIV_STEP_W = $clog2(DIV_W);

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Slot geometry limits and reset values.
   localparam logic [BYTES_W-1:0] MIN_SLOT_BYTES   = 13'd4;
   localparam logic [BYTES_W-1:0] RESET_SLOT_BYTES = 13'd64;
   localparam logic [COUNT_W-1:0] RESET_SLOT_COUNT = 11'd1024;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_SLOT_BYTES = 1'b0,
      CSR_SLOT_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_LARGE = 3'd1,
      STATUS_EXHAUSTED = 3'd2,
      STATUS_BAD_ALIGN = 3'd3,
      STATUS_BAD_ADDR  = 3'd4
   } status_type;

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      req_kind_type         kind;
      logic                 align_zero;
      logic                 too_large;
      logic [DIV_W-1:0]     dividend;
      logic [BYTES_W-1:0]   divisor;
   } cmd_type;

   // Effective slot geometry after clamping.
   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [COUNT_W-1:0] count;
   } geom_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [BYTES_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quotient;
      logic [BYTES_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> hw/rtl/fsfl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the free-list links of the allocator.
module fsfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fsfl_div.sv
// Restoring divider, one quotient bit per cycle, for offsets and alignments.
// Depends on fsfl_pkg for widths and the request and response structs.
module fsfl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fsfl_pkg::div_req_type div_req,
   output fsfl_pkg::div_rsp_type div_rsp
);

   import fsfl_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [BYTES_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [BYTES_W-1:0]    dvs_ff, dvs_in;
   logic [BYTES_W:0]      rem_shift;
   logic [BYTES_W:0]      rem_diff;
   logic                  fits;

   // One trial subtraction of the partial remainder.
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = (rem_shift >= {1'b0, dvs_ff});

   // Step control.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      priority if (div_req.start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(DIV_W - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? rem_diff[BYTES_W-1:0] : rem_shift[BYTES_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> hw/rtl/fsfl_queue.sv
// Short command queue that decouples the request front from the back end.
// Depends on fsfl_pkg for the command struct and the queue depth.
`include "fixed_slot_free_list_allocator_macros.svh"

module fsfl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fsfl_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output fsfl_pkg::cmd_type pop_cmd
);

   import fsfl_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];

   `FSFL_ASSERT_IMPL(a_no_push_when_full, clock, reset, push, count_ff != CNT_W'(QUEUE_DEPTH), "command pushed into a full queue")
   `FSFL_ASSERT_NEXT(a_push_shows_valid, clock, reset, push && !pop, pop_valid, "pushed command not visible at the queue head")

endmodule

>>> hw/rtl/fsfl_front.sv
// Request front: takes request beats, classifies them and sets up the divider operands.
// Depends on fsfl_pkg for the command and geometry structs.
module fsfl_front (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [fsfl_pkg::REQ_BYTES_W-1:0] req_request_bytes,
   input  logic [fsfl_pkg::ALIGN_W-1:0]     req_alignment,
   input  logic [fsfl_pkg::OFFSET_W-1:0]    req_free_offset,
   input  fsfl_pkg::geom_type               geom,
   input  logic                             sweep_busy,
   input  logic                             q_ready,
   output logic                             q_push,
   output fsfl_pkg::cmd_type                q_cmd
);

   import fsfl_pkg::*;

   req_kind_type kind;

   assign kind = req_kind_type'(req_type);

   // No beat is taken while the free list is being rebuilt.
   assign req_ready = q_ready && !sweep_busy;
   assign q_push    = req_valid && req_ready;

   // An allocate divides the slot size by the alignment; a free divides the
   // offset by the slot size.
   always_comb begin
      q_cmd.kind = kind;
      unique case (kind)
         REQ_ALLOC: begin
            q_cmd.align_zero = (req_alignment == '0);
            q_cmd.too_large  = (req_request_bytes > REQ_BYTES_W'(geom.bytes));
            q_cmd.dividend   = DIV_W'(geom.bytes);
            q_cmd.divisor    = req_alignment;
         end
         REQ_FREE: begin
            q_cmd.align_zero = 1'b0;
            q_cmd.too_large  = 1'b0;
            q_cmd.dividend   = req_free_offset;
            q_cmd.divisor    = geom.bytes;
         end
      endcase
   end

endmodule

>>> hw/rtl/fsfl_back.sv
// Back end: slot geometry registers, free-list rebuild, divider and list update.
// Depends on fsfl_pkg, fsfl_div and fsfl_ram.
`include "fixed_slot_free_list_allocator_macros.svh"

module fsfl_back #(
   parameter int SLOTS          = 1024,
   parameter int MAX_SLOT_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  fsfl_pkg::csr_index_type       csr_index,
   input  logic [fsfl_pkg::BYTES_W-1:0]  csr_wdata,
   input  logic                          q_valid,
   input  fsfl_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output fsfl_pkg::geom_type            geom,
   output logic                          sweep_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fsfl_pkg::STATUS_W-1:0] rsp_status,
   output logic [fsfl_pkg::OFFSET_W-1:0] rsp_slot_offset,
   output logic [fsfl_pkg::COUNT_W-1:0]  rsp_free_slots
);

   import fsfl_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int MW = IW + 1;
   localparam int PW = IW + BYTES_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_POP  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [BYTES_W-1:0]   slot_bytes_ff, slot_bytes_in;
   logic [COUNT_W-1:0]   slot_count_ff, slot_count_in;
   logic                 sweep_busy_ff, sweep_busy_in;
   logic [IW-1:0]        sweep_idx_ff, sweep_idx_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IW-1:0]        head_ff, head_in;
   logic                 head_ok_ff, head_ok_in;
   logic [COUNT_W-1:0]   free_total_ff, free_total_in;
   status_type           res_status_ff, res_status_in;
   logic [OFFSET_W-1:0]  res_offset_ff, res_offset_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [COUNT_W-1:0]   rsp_free_ff, rsp_free_in;

   logic [BYTES_W-1:0]   eff_bytes;
   logic [COUNT_W-1:0]   eff_count;
   logic [PW-1:0]        prod;
   logic                 sweep_live;
   logic [MW-1:0]        sweep_data;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [MW-1:0]        ram_wr_data;
   logic                 ram_rd_en;
   logic [IW-1:0]        ram_rd_addr;
   logic [MW-1:0]        ram_rd_data;

   // Clamp the configured geometry to its legal range.
   always_comb begin
      priority if (slot_bytes_ff < MIN_SLOT_BYTES) begin
         eff_bytes = MIN_SLOT_BYTES;
      end else if (32'(slot_bytes_ff) > 32'(MAX_SLOT_BYTES)) begin
         eff_bytes = BYTES_W'(MAX_SLOT_BYTES);
      end else begin
         eff_bytes = slot_bytes_ff;
      end
      priority if (slot_count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (32'(slot_count_ff) > 32'(SLOTS)) begin
         eff_count = COUNT_W'(SLOTS);
      end else begin
         eff_count = slot_count_ff;
      end
   end

   assign geom.bytes = eff_bytes;
   assign geom.count = eff_count;
   assign sweep_busy = sweep_busy_ff;

   // Register writes, and the rebuild sweep that every write restarts.
   always_comb begin
      slot_bytes_in = slot_bytes_ff;
      slot_count_in = slot_count_ff;
      sweep_busy_in = sweep_busy_ff;
      sweep_idx_in  = sweep_idx_ff;
      priority if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SLOT_BYTES: slot_bytes_in = csr_wdata;
            CSR_SLOT_COUNT: slot_count_in = csr_wdata[COUNT_W-1:0];
         endcase
         sweep_busy_in = 1'b1;
         sweep_idx_in  = '0;
      end else if (sweep_busy_ff) begin
         if (sweep_idx_ff == IW'(SLOTS - 1)) begin
            sweep_busy_in = 1'b0;
         end else begin
            sweep_idx_in = sweep_idx_ff + 1'b1;
         end
      end else begin
         sweep_busy_in = 1'b0;
      end
   end

   // Slot i links to slot i-1 for every slot in use except slot zero.
   assign sweep_live = (sweep_idx_ff != '0) && (32'(sweep_idx_ff) < 32'(eff_count));
   assign sweep_data = sweep_live ? {1'b1, sweep_idx_ff - 1'b1} : '0;

   // Byte offset of the head slot.
   assign prod = PW'(head_ff) * PW'(eff_bytes);

   // Sequencer: start the divider, decide the outcome, update the list.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      head_in       = head_ff;
      head_ok_in    = head_ok_ff;
      free_total_in = free_total_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;
      q_pop         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_cmd.dividend;
      div_req.divisor  = q_cmd.divisor;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_idx_ff;
      ram_wr_data   = sweep_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !sweep_busy_ff) begin
               q_pop         = 1'b1;
               div_req.start = 1'b1;
               cmd_in        = q_cmd;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_offset_in = '0;
               state_in      = ST_RESP;
               unique case (cmd_ff.kind)
                  REQ_ALLOC: begin
                     priority if (cmd_ff.align_zero || (div_rsp.remainder != '0)) begin
                        res_status_in = STATUS_BAD_ALIGN;
                     end else if (cmd_ff.too_large) begin
                        res_status_in = STATUS_TOO_LARGE;
                     end else if (!head_ok_ff) begin
                        res_status_in = STATUS_EXHAUSTED;
                     end else begin
                        res_status_in = STATUS_OK;
                        res_offset_in = OFFSET_W'(prod);
                        ram_rd_en     = 1'b1;
                        state_in      = ST_POP;
                     end
                  end
                  REQ_FREE: begin
                     if ((div_rsp.remainder != '0) ||
                         (div_rsp.quotient >= DIV_W'(eff_count))) begin
                        res_status_in = STATUS_BAD_ADDR;
                     end else begin
                        res_status_in = STATUS_OK;
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = IW'(div_rsp.quotient);
                        ram_wr_data   = {head_ok_ff, head_ff};
                        head_in       = IW'(div_rsp.quotient);
                        head_ok_in    = 1'b1;
                        free_total_in = free_total_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_POP: begin
            head_in       = ram_rd_data[IW-1:0];
            head_ok_in    = ram_rd_data[IW];
            free_total_in = free_total_ff - 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               rsp_free_in   = free_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The rebuild owns the write port and resets head and count.
      if (sweep_busy_ff) begin
         ram_wr_en     = 1'b1;
         ram_wr_addr   = sweep_idx_ff;
         ram_wr_data   = sweep_data;
         head_in       = IW'(eff_count - 1'b1);
         head_ok_in    = 1'b1;
         free_total_in = eff_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_bytes_ff <= RESET_SLOT_BYTES;
         slot_count_ff <= RESET_SLOT_COUNT;
         sweep_busy_ff <= 1'b1;
         sweep_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_bytes_ff <= slot_bytes_in;
         slot_count_ff <= slot_count_in;
         sweep_busy_ff <= sweep_busy_in;
         sweep_idx_ff  <= sweep_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      head_ff       <= head_in;
      head_ok_ff    <= head_ok_in;
      free_total_ff <= free_total_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_free_ff   <= rsp_free_in;
   end

   fsfl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Free-list links: the low bits hold the next slot, the top bit marks it valid.
   fsfl_ram #(
      .WIDTH (MW),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_offset = rsp_offset_ff;
   assign rsp_free_slots  = rsp_free_ff;

   `FSFL_ASSERT_IMPL(a_no_start_in_sweep, clock, reset, sweep_busy_ff, !q_pop, "request started during free-list rebuild")
   `FSFL_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `FSFL_ASSERT_IMPL(a_ram_single_access, clock, reset, ram_rd_en, !ram_wr_en, "link memory read and written in the same cycle")

endmodule

>>> hw/rtl/fixed_slot_free_list_allocator.sv
// Fixed-slot pool allocator with an index-linked free list.
// Each request passes the command queue, the shared 22-step divider and the result
// registers; a successful allocate also reads the next link. The back end serves one
// request at a time; the queue holds up to two more. Reset and every register write
// rebuild all SLOTS links (1024 by default), during which no request beat is taken.
module fixed_slot_free_list_allocator #(
   parameter int SLOTS          = 1024,
   parameter int MAX_SLOT_BYTES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  fsfl_pkg::csr_index_type          csr_index,
   input  logic [fsfl_pkg::BYTES_W-1:0]     csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [fsfl_pkg::REQ_BYTES_W-1:0] req_request_bytes,
   input  logic [fsfl_pkg::ALIGN_W-1:0]     req_alignment,
   input  logic [fsfl_pkg::OFFSET_W-1:0]    req_free_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fsfl_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fsfl_pkg::OFFSET_W-1:0]    rsp_slot_offset,
   output logic [fsfl_pkg::COUNT_W-1:0]     rsp_free_slots
);

   import fsfl_pkg::*;

   geom_type geom;
   logic     sweep_busy;
   logic     q_ready;
   logic     q_push;
   cmd_type  q_push_cmd;
   logic     q_valid;
   logic     q_pop;
   cmd_type  q_pop_cmd;

   // Front: classify request beats.
   fsfl_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_request_bytes (req_request_bytes),
      .req_alignment     (req_alignment),
      .req_free_offset   (req_free_offset),
      .geom              (geom),
      .sweep_busy        (sweep_busy),
      .q_ready           (q_ready),
      .q_push            (q_push),
      .q_cmd             (q_push_cmd)
   );

   // Command queue between front and back.
   fsfl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_pop_cmd)
   );

   // Back: divide, update the free list and hold the result.
   fsfl_back #(
      .SLOTS          (SLOTS),
      .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_valid         (q_valid),
      .q_cmd           (q_pop_cmd),
      .q_pop           (q_pop),
      .geom            (geom),
      .sweep_busy      (sweep_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot_offset (rsp_slot_offset),
      .rsp_free_slots  (rsp_free_slots)
   );

endmodule
